### hw/rtl/srpg_pkg.sv
`timescale 1ns / 1ps
package srpg_pkg;

   localparam int CountWidth = 31;
   localparam int RateWidth = 15;
   localparam int DvdWidth = 48;
   localparam int DvsWidth = 34;
   localparam int DivSteps = DvdWidth;
   localparam int DivCntWidth = $clog2(DivSteps);
   localparam int ReqDataWidth = 40;
   localparam int RspDataWidth = 72;
   localparam int CsrIndexWidth = 3;

   localparam logic [CountWidth-1:0] Max31 = {CountWidth{1'b1}};

   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_STEP  = 3'd1;
   localparam logic [2:0] OP_ALTER = 3'd2;
   localparam logic [2:0] OP_BRAKE = 3'd3;
   localparam logic [2:0] OP_STOP  = 3'd4;

   localparam logic [1:0] PH_STOPPED = 2'd0;
   localparam logic [1:0] PH_ACCEL   = 2'd1;
   localparam logic [1:0] PH_CRUISE  = 2'd2;
   localparam logic [1:0] PH_DECEL   = 2'd3;

   localparam logic [CsrIndexWidth-1:0] CSR_MODE   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_ACCEL  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_DECEL  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_RAMP   = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_FIRST  = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_CRUISE = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH, ST_MUL_PLAN, ST_MUL_SHORT, ST_MUL_BRK,
      ST_DIV_GO, ST_DIV_WAIT, ST_APPLY, ST_SHORT_CHK, ST_FINISH
   } state_type;

   typedef enum logic [1:0] {JOB_PLAN, JOB_SHORT, JOB_BRK, JOB_STEP} job_type;

   typedef enum logic [3:0] {
      CMD_NONE, CMD_EXEC, CMD_MUL_PLAN, CMD_MUL_SHORT, CMD_MUL_BRK, CMD_DIV_GO,
      CMD_SET_BRAKE, CMD_SET_SHORT, CMD_SET_BRK, CMD_SET_STEP, CMD_FINISH
   } dp_cmd_type;

   typedef struct packed {
      logic plan_req;
      logic brk_req;
      logic recur_req;
      logic short_move;
      logic div_done;
   } dp_status_type;

   function automatic logic [1:0] phase_of(input logic [CountWidth-1:0] rem,
                                           input logic [CountWidth-1:0] done,
                                           input logic [CountWidth-1:0] alim,
                                           input logic [CountWidth-1:0] blim);
      logic [1:0] ph;
      if (rem == '0) ph = PH_STOPPED;
      else if (rem <= blim) ph = PH_DECEL;
      else if (done <= alim) ph = PH_ACCEL;
      else ph = PH_CRUISE;
      return ph;
   endfunction

endpackage

### hw/rtl/stepper_ramp_pulse_generator.sv
`timescale 1ns / 1ps
// Stepper move planner and step-interval generator. Each request carries a command
// (start move, issue step, alter move, brake, stop) and yields exactly one response
// with the step flag, direction, interval to wait, motion phase and steps left.
// Linear mode plans an acceleration ramp from the ramp_steps, first_pulse_us and
// cruise_pulse_us registers and walks the interval with p -= (2p+r)/(4n+1) while
// accelerating and p += (2p+r)/(4m-1) while decelerating, m being the steps left.
// Structure: one request at a time through a controller and a datapath sharing one
// multiplier and one radix-2 divider that yields one quotient bit per cycle. A step
// inside a ramp runs one division, a brake during acceleration and a linear start a
// multiply and a division, a shortened start a second pair; the rest use neither.
// A finished response waits in an output register while the next request is taken.
// Configuration writes are taken every cycle and must land only while idle.
module stepper_ramp_pulse_generator (
   input  logic                                clock,
   input  logic                                reset,
   // request: [2:0] opcode, [34:3] step_amount
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [srpg_pkg::ReqDataWidth-1:0]   req_tdata,
   // response: [0] step_issued, [1] direction, [32:2] interval_us,
   // [34:33] motion_state, [65:35] steps_left
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [srpg_pkg::RspDataWidth-1:0]   rsp_tdata,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [srpg_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [srpg_pkg::CountWidth-1:0]     csr_data
);

   srpg_pkg::dp_cmd_type    cmd;
   srpg_pkg::dp_status_type status;
   logic                    step_issued, direction;
   logic [srpg_pkg::CountWidth-1:0] interval_us, steps_left;
   logic [1:0]              motion_state;

   // register writes never stall
   assign csr_ready = 1'b1;

   srpg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   srpg_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .opcode       (req_tdata[2:0]),
      .step_amount  (req_tdata[34:3]),
      .csr_we       (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .step_issued  (step_issued),
      .direction    (direction),
      .interval_us  (interval_us),
      .motion_state (motion_state),
      .steps_left   (steps_left)
   );

   // pack the response, zero fill to whole bytes
   assign rsp_tdata = {6'b0, steps_left, motion_state, interval_us, direction, step_issued};

endmodule

### hw/rtl/srpg_div.sv
`timescale 1ns / 1ps
module srpg_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [srpg_pkg::DvdWidth-1:0]     dividend,
   input  logic [srpg_pkg::DvsWidth-1:0]     divisor,
   output logic                              busy,
   output logic [srpg_pkg::DvdWidth-1:0]     quotient,
   output logic [srpg_pkg::DvsWidth-1:0]     remainder
);

   logic                              busy_ff, busy_in;
   logic [srpg_pkg::DivCntWidth-1:0]  cnt_ff, cnt_in;
   logic [srpg_pkg::DvdWidth-1:0]     quo_ff, quo_in;
   logic [srpg_pkg::DvsWidth-1:0]     rmd_ff, rmd_in;
   logic [srpg_pkg::DvsWidth:0]       shifted, trial;

   // one quotient bit per cycle, restoring
   always_comb begin
      shifted = {rmd_ff, quo_ff[srpg_pkg::DvdWidth-1]};
      trial = shifted - {1'b0, divisor};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rmd_in = rmd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rmd_in = '0;
      end else if (busy_ff) begin
         if (trial[srpg_pkg::DvsWidth]) begin
            rmd_in = shifted[srpg_pkg::DvsWidth-1:0];
         end else begin
            rmd_in = trial[srpg_pkg::DvsWidth-1:0];
         end
         quo_in = {quo_ff[srpg_pkg::DvdWidth-2:0], ~trial[srpg_pkg::DvsWidth]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == srpg_pkg::DivCntWidth'(srpg_pkg::DivSteps - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rmd_ff <= rmd_in;
   end

   assign busy = busy_ff;
   assign quotient = quo_ff;
   assign remainder = rmd_ff;

endmodule

### hw/rtl/srpg_ctrl.sv
`timescale 1ns / 1ps
module srpg_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  srpg_pkg::dp_status_type status,
   output srpg_pkg::dp_cmd_type    cmd
);

   srpg_pkg::state_type state_ff, state_in;
   srpg_pkg::job_type   job_ff, job_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srpg_pkg::ST_IDLE: if (req_tvalid) state_in = srpg_pkg::ST_DISPATCH;
         srpg_pkg::ST_DISPATCH: begin
            priority if (status.plan_req) state_in = srpg_pkg::ST_MUL_PLAN;
            else if (status.brk_req) state_in = srpg_pkg::ST_MUL_BRK;
            else if (status.recur_req) state_in = srpg_pkg::ST_DIV_GO;
            else state_in = srpg_pkg::ST_FINISH;
         end
         srpg_pkg::ST_MUL_PLAN, srpg_pkg::ST_MUL_SHORT, srpg_pkg::ST_MUL_BRK:
            state_in = srpg_pkg::ST_DIV_GO;
         srpg_pkg::ST_DIV_GO: state_in = srpg_pkg::ST_DIV_WAIT;
         srpg_pkg::ST_DIV_WAIT: if (status.div_done) state_in = srpg_pkg::ST_APPLY;
         srpg_pkg::ST_APPLY: begin
            if (job_ff == srpg_pkg::JOB_PLAN) state_in = srpg_pkg::ST_SHORT_CHK;
            else state_in = srpg_pkg::ST_FINISH;
         end
         srpg_pkg::ST_SHORT_CHK: begin
            if (status.short_move) state_in = srpg_pkg::ST_MUL_SHORT;
            else state_in = srpg_pkg::ST_FINISH;
         end
         srpg_pkg::ST_FINISH: if (!rsp_valid_ff || rsp_tready) state_in = srpg_pkg::ST_IDLE;
         default: state_in = srpg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = srpg_pkg::CMD_NONE;
      job_in = job_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         srpg_pkg::ST_IDLE: if (req_tvalid) cmd = srpg_pkg::CMD_EXEC;
         srpg_pkg::ST_DISPATCH: job_in = srpg_pkg::JOB_STEP;
         srpg_pkg::ST_MUL_PLAN: begin
            cmd = srpg_pkg::CMD_MUL_PLAN;
            job_in = srpg_pkg::JOB_PLAN;
         end
         srpg_pkg::ST_MUL_SHORT: begin
            cmd = srpg_pkg::CMD_MUL_SHORT;
            job_in = srpg_pkg::JOB_SHORT;
         end
         srpg_pkg::ST_MUL_BRK: begin
            cmd = srpg_pkg::CMD_MUL_BRK;
            job_in = srpg_pkg::JOB_BRK;
         end
         srpg_pkg::ST_DIV_GO: cmd = srpg_pkg::CMD_DIV_GO;
         srpg_pkg::ST_DIV_WAIT: cmd = srpg_pkg::CMD_NONE;
         srpg_pkg::ST_APPLY: begin
            unique case (job_ff)
               srpg_pkg::JOB_PLAN:  cmd = srpg_pkg::CMD_SET_BRAKE;
               srpg_pkg::JOB_SHORT: cmd = srpg_pkg::CMD_SET_SHORT;
               srpg_pkg::JOB_BRK:   cmd = srpg_pkg::CMD_SET_BRK;
               srpg_pkg::JOB_STEP:  cmd = srpg_pkg::CMD_SET_STEP;
               default:             cmd = srpg_pkg::CMD_NONE;
            endcase
         end
         srpg_pkg::ST_SHORT_CHK: cmd = srpg_pkg::CMD_NONE;
         srpg_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd = srpg_pkg::CMD_FINISH;
               rsp_valid_in = 1'b1;
            end
         end
         default: cmd = srpg_pkg::CMD_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srpg_pkg::ST_IDLE;
         job_ff <= srpg_pkg::JOB_STEP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         job_ff <= job_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == srpg_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

### hw/rtl/srpg_dp.sv
`timescale 1ns / 1ps
module srpg_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  srpg_pkg::dp_cmd_type                cmd,
   output srpg_pkg::dp_status_type             status,
   input  logic [2:0]                          opcode,
   input  logic signed [31:0]                  step_amount,
   input  logic                                csr_we,
   input  logic [srpg_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [srpg_pkg::CountWidth-1:0]     csr_data,
   output logic                                step_issued,
   output logic                                direction,
   output logic [srpg_pkg::CountWidth-1:0]     interval_us,
   output logic [1:0]                          motion_state,
   output logic [srpg_pkg::CountWidth-1:0]     steps_left
);

   localparam int CW = srpg_pkg::CountWidth;
   localparam int RW = srpg_pkg::RateWidth;

   // configuration
   logic          mode_ff, mode_in;
   logic [RW-1:0] arate_ff, arate_in, drate_ff, drate_in;
   logic [CW-1:0] ramp_ff, ramp_in, first_ff, first_in, cruise_ff, cruise_in;

   // move state
   logic [CW-1:0] rem_ff, rem_in, done_ff, done_in, alim_ff, alim_in, blim_ff, blim_in;
   logic [CW-1:0] pulse_ff, pulse_in, clat_ff, clat_in;
   logic [31:0]   rest_ff, rest_in;
   logic          fwd_ff, fwd_in;

   // per-request working state
   logic          plan_ff, plan_in, brk_ff, brk_in, recur_ff, recur_in;
   logic          issued_ff, issued_in, stop_ff, stop_in;
   logic [CW-1:0] ival_ff, ival_in, left_ff, left_in;
   logic          nneg_ff, nneg_in, dneg_ff, dneg_in;
   logic [srpg_pkg::DvdWidth-1:0] dvd_ff, dvd_in;
   logic [srpg_pkg::DvsWidth-1:0] dvs_ff, dvs_in;

   // result register
   logic          o_iss_ff, o_iss_in, o_dir_ff, o_dir_in;
   logic [CW-1:0] o_ival_ff, o_ival_in, o_left_ff, o_left_in;
   logic [1:0]    o_ph_ff, o_ph_in;

   logic [RW-1:0] a_nz, d_nz;
   logic [1:0]    ph, ph1;
   logic [31:0]   mag32;
   logic [CW-1:0] mag31, rem1, done1;
   logic [31:0]   sum32;
   logic [32:0]   floor33;
   logic [33:0]   num34, nmag;
   logic [CW-1:0] mul_a;
   logic [RW-1:0] mul_b;
   logic [CW+RW-1:0] prod;
   logic [srpg_pkg::DvdWidth-1:0] quo;
   logic [srpg_pkg::DvsWidth-1:0] rmd;
   logic          div_busy;
   logic [35:0]   qs, pn, rs;
   logic [CW:0]   lim_sum;

   srpg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd == srpg_pkg::CMD_DIV_GO),
      .dividend  (dvd_ff),
      .divisor   (dvs_ff),
      .busy      (div_busy),
      .quotient  (quo),
      .remainder (rmd)
   );

   assign a_nz = (arate_ff == '0) ? RW'(1) : arate_ff;
   assign d_nz = (drate_ff == '0) ? RW'(1) : drate_ff;
   assign ph = srpg_pkg::phase_of(rem_ff, done_ff, alim_ff, blim_ff);
   assign lim_sum = {1'b0, alim_ff} + {1'b0, blim_ff};

   assign status.plan_req = plan_ff;
   assign status.brk_req = brk_ff;
   assign status.recur_req = recur_ff;
   assign status.short_move = {1'b0, rem_ff} < lim_sum;
   assign status.div_done = !div_busy;

   // shared multiplier operands
   always_comb begin
      mul_a = done_ff;
      mul_b = a_nz;
      unique case (cmd)
         srpg_pkg::CMD_MUL_PLAN: begin
            mul_a = alim_ff;
            mul_b = a_nz;
         end
         srpg_pkg::CMD_MUL_SHORT: begin
            mul_a = rem_ff;
            mul_b = d_nz;
         end
         default: begin
            mul_a = done_ff;
            mul_b = a_nz;
         end
      endcase
   end
   assign prod = mul_a * mul_b;

   always_comb begin
      mode_in = mode_ff; arate_in = arate_ff; drate_in = drate_ff;
      ramp_in = ramp_ff; first_in = first_ff; cruise_in = cruise_ff;
      rem_in = rem_ff; done_in = done_ff; alim_in = alim_ff; blim_in = blim_ff;
      pulse_in = pulse_ff; clat_in = clat_ff; rest_in = rest_ff; fwd_in = fwd_ff;
      plan_in = plan_ff; brk_in = brk_ff; recur_in = recur_ff;
      issued_in = issued_ff; stop_in = stop_ff; ival_in = ival_ff; left_in = left_ff;
      nneg_in = nneg_ff; dneg_in = dneg_ff; dvd_in = dvd_ff; dvs_in = dvs_ff;
      o_iss_in = o_iss_ff; o_dir_in = o_dir_ff; o_ival_in = o_ival_ff;
      o_left_in = o_left_ff; o_ph_in = o_ph_ff;

      mag32 = step_amount[31] ? (~step_amount + 32'd1) : step_amount;
      mag31 = mag32[31] ? srpg_pkg::Max31 : mag32[CW-1:0];
      sum32 = {1'b0, rem_ff} + {1'b0, step_amount[CW-1:0]};
      floor33 = {2'b0, blim_ff} + {1'b0, mag32};
      rem1 = rem_ff - CW'(1);
      done1 = (done_ff != srpg_pkg::Max31) ? done_ff + CW'(1) : done_ff;
      ph1 = srpg_pkg::phase_of(rem1, done1, alim_ff, blim_ff);
      num34 = {2'b0, pulse_ff, 1'b0} + {{2{rest_ff[31]}}, rest_ff};
      nmag = num34[33] ? (~num34 + 34'd1) : num34;
      qs = (nneg_ff ^ dneg_ff) ? (36'd0 - {2'b0, quo[33:0]}) : {2'b0, quo[33:0]};
      pn = {5'b0, pulse_ff} - qs;
      rs = nneg_ff ? (36'd0 - {2'b0, rmd}) : {2'b0, rmd};

      if (csr_we) begin
         unique case (csr_index)
            srpg_pkg::CSR_MODE:   mode_in = csr_data[0];
            srpg_pkg::CSR_ACCEL:  arate_in = csr_data[RW-1:0];
            srpg_pkg::CSR_DECEL:  drate_in = csr_data[RW-1:0];
            srpg_pkg::CSR_RAMP:   ramp_in = csr_data;
            srpg_pkg::CSR_FIRST:  first_in = csr_data;
            srpg_pkg::CSR_CRUISE: cruise_in = csr_data;
            default: ;
         endcase
      end

      unique case (cmd)
         srpg_pkg::CMD_EXEC: begin
            plan_in = 1'b0; brk_in = 1'b0; recur_in = 1'b0;
            issued_in = 1'b0; ival_in = '0;
            stop_in = (opcode == srpg_pkg::OP_STOP);
            priority if (opcode == srpg_pkg::OP_START ||
                         (opcode == srpg_pkg::OP_ALTER && ph == srpg_pkg::PH_STOPPED)) begin
               fwd_in = !step_amount[31];
               rem_in = mag31;
               done_in = '0;
               rest_in = '0;
               clat_in = cruise_ff;
               if (mode_ff) begin
                  alim_in = ramp_ff;
                  pulse_in = first_ff;
                  plan_in = 1'b1;
               end else begin
                  alim_in = '0;
                  blim_in = '0;
                  pulse_in = cruise_ff;
               end
            end else if (opcode == srpg_pkg::OP_ALTER) begin
               if (ph != srpg_pkg::PH_DECEL) begin
                  if (!step_amount[31]) begin
                     rem_in = sum32[31] ? srpg_pkg::Max31 : sum32[CW-1:0];
                  end else if ({2'b0, rem_ff} > floor33) begin
                     rem_in = rem_ff - mag32[CW-1:0];
                  end else begin
                     rem_in = blim_ff;
                  end
               end
            end else if (opcode == srpg_pkg::OP_BRAKE) begin
               if (ph == srpg_pkg::PH_CRUISE) rem_in = blim_ff;
               else if (ph == srpg_pkg::PH_ACCEL) brk_in = 1'b1;
            end else if (opcode == srpg_pkg::OP_STEP) begin
               if (rem_ff != '0) begin
                  issued_in = 1'b1;
                  ival_in = pulse_ff;
                  rem_in = rem1;
                  done_in = done1;
                  nneg_in = num34[33];
                  dvd_in = {{(srpg_pkg::DvdWidth-34){1'b0}}, nmag};
                  if (mode_ff && ph1 == srpg_pkg::PH_ACCEL) begin
                     if (done1 < alim_ff) begin
                        recur_in = 1'b1;
                        dneg_in = 1'b0;
                        dvs_in = {1'b0, done1, 2'b01};
                     end else begin
                        pulse_in = clat_ff;
                        rest_in = '0;
                     end
                  end else if (mode_ff && ph1 == srpg_pkg::PH_DECEL) begin
                     recur_in = 1'b1;
                     dneg_in = 1'b1;
                     dvs_in = {1'b0, rem1, 2'b00} - 34'd1;
                  end
               end
            end else if (opcode == srpg_pkg::OP_STOP) begin
               left_in = rem_ff;
               rem_in = '0;
            end else begin
               // unknown opcode leaves the move untouched
               stop_in = 1'b0;
            end
         end
         srpg_pkg::CMD_MUL_PLAN, srpg_pkg::CMD_MUL_BRK: begin
            dvd_in = {{(srpg_pkg::DvdWidth-CW-RW){1'b0}}, prod};
            dvs_in = {{(srpg_pkg::DvsWidth-RW){1'b0}}, d_nz};
            plan_in = 1'b0;
            brk_in = 1'b0;
         end
         srpg_pkg::CMD_MUL_SHORT: begin
            dvd_in = {{(srpg_pkg::DvdWidth-CW-RW){1'b0}}, prod};
            dvs_in = {{(srpg_pkg::DvsWidth-RW-1){1'b0}}, {1'b0, a_nz} + {1'b0, d_nz}};
         end
         srpg_pkg::CMD_SET_BRAKE: begin
            blim_in = (|quo[srpg_pkg::DvdWidth-1:CW]) ? srpg_pkg::Max31 : quo[CW-1:0];
         end
         srpg_pkg::CMD_SET_SHORT: begin
            alim_in = quo[CW-1:0];
            blim_in = rem_ff - quo[CW-1:0];
         end
         srpg_pkg::CMD_SET_BRK: begin
            rem_in = (|quo[srpg_pkg::DvdWidth-1:CW]) ? srpg_pkg::Max31 : quo[CW-1:0];
         end
         srpg_pkg::CMD_SET_STEP: begin
            recur_in = 1'b0;
            if (pn[35]) pulse_in = '0;
            else if (|pn[34:CW]) pulse_in = srpg_pkg::Max31;
            else pulse_in = pn[CW-1:0];
            if (!rs[35] && (|rs[34:31])) rest_in = 32'h7FFF_FFFF;
            else if (rs[35] && !(&rs[34:31])) rest_in = 32'h8000_0000;
            else rest_in = rs[31:0];
         end
         srpg_pkg::CMD_FINISH: begin
            o_iss_in = issued_ff;
            o_dir_in = fwd_ff;
            o_ival_in = ival_ff;
            o_ph_in = ph;
            o_left_in = stop_ff ? left_ff : rem_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         arate_ff <= RW'(1000);
         drate_ff <= RW'(1000);
         ramp_ff <= '0;
         first_ff <= CW'(1000);
         cruise_ff <= CW'(1000);
         rem_ff <= '0;
         done_ff <= '0;
         alim_ff <= '0;
         blim_ff <= '0;
         pulse_ff <= '0;
         clat_ff <= '0;
         rest_ff <= '0;
         fwd_ff <= 1'b0;
         plan_ff <= 1'b0;
         brk_ff <= 1'b0;
         recur_ff <= 1'b0;
         issued_ff <= 1'b0;
         stop_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         arate_ff <= arate_in;
         drate_ff <= drate_in;
         ramp_ff <= ramp_in;
         first_ff <= first_in;
         cruise_ff <= cruise_in;
         rem_ff <= rem_in;
         done_ff <= done_in;
         alim_ff <= alim_in;
         blim_ff <= blim_in;
         pulse_ff <= pulse_in;
         clat_ff <= clat_in;
         rest_ff <= rest_in;
         fwd_ff <= fwd_in;
         plan_ff <= plan_in;
         brk_ff <= brk_in;
         recur_ff <= recur_in;
         issued_ff <= issued_in;
         stop_ff <= stop_in;
      end
      ival_ff <= ival_in;
      left_ff <= left_in;
      nneg_ff <= nneg_in;
      dneg_ff <= dneg_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      o_iss_ff <= o_iss_in;
      o_dir_ff <= o_dir_in;
      o_ival_ff <= o_ival_in;
      o_ph_ff <= o_ph_in;
      o_left_ff <= o_left_in;
   end

   assign step_issued = o_iss_ff;
   assign direction = o_dir_ff;
   assign interval_us = o_ival_ff;
   assign motion_state = o_ph_ff;
   assign steps_left = o_left_ff;

endmodule

### hw/rtl/srpg_checker.sv
`timescale 1ns / 1ps
module srpg_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [srpg_pkg::RspDataWidth-1:0]   rsp_tdata
);

   // a held response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   // no step, no interval
   a_no_step_interval: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[32:2] == '0)
      else $error("interval without a step");

   // one request in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // nothing comes out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("response right after reset");

endmodule

bind stepper_ramp_pulse_generator srpg_checker u_srpg_checker (.*);
